>>> design/tcpck_pkg.sv
// Shared types and constants for the TCP checksum unit.
// No dependencies; imported by the front, back and top-level modules.
package tcpck_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_SOURCE_IP       = 3'd0;
	localparam logic [2:0] REG_DEST_IP         = 3'd1;
	localparam logic [2:0] REG_PSEUDO_RESERVED = 3'd2;
	localparam logic [2:0] REG_PROTOCOL_NUMBER = 3'd3;

	localparam logic [7:0]  PROTOCOL_RESET  = 8'd6;
	// byte offset of the checksum field inside the TCP header
	localparam logic [15:0] CSUM_FIELD_BYTE = 16'd16;

	// per-segment totals handed from front to back
	typedef struct packed {
		logic [15:0] sum;
		logic [15:0] bytes;
		logic        sat;
	} seg_total_t;

	// pseudo-header configuration
	typedef struct packed {
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [7:0]  pseudo_reserved;
		logic [7:0]  protocol_number;
	} pseudo_cfg_t;

endpackage

>>> design/tcpck_fifo.sv
// Small flop-based queue that decouples the front and back parts.
// No package dependencies.
module tcpck_fifo #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	// store payload
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> design/tcpck_front.sv
// Front part: accumulates segment words into a running ones-complement sum
// and byte count, and emits per-segment totals on the last word. Uses tcpck_pkg.
module tcpck_front import tcpck_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [15:0] segment_word,
	input  logic        last_word,
	input  logic        single_byte,
	output logic        total_push,
	output seg_total_t  total_data
);
	logic [15:0] sum_q;
	logic [15:0] count_q;
	logic        sat_q;

	logic        half;
	logic        is_csum;
	logic [15:0] word_m;
	logic [16:0] raw_sum;
	logic [15:0] new_sum;
	logic [16:0] raw_count;
	logic [15:0] new_count;
	logic        new_sat;

	// mask the word, zero the checksum field, add with end-around carry
	always_comb begin
		half      = last_word && single_byte;
		is_csum   = !sat_q && (count_q == CSUM_FIELD_BYTE);
		word_m    = half ? {segment_word[15:8], 8'h00} : segment_word;
		if (is_csum) begin
			word_m = '0;
		end
		raw_sum   = {1'b0, sum_q} + {1'b0, word_m};
		new_sum   = raw_sum[15:0] + {15'd0, raw_sum[16]};
		raw_count = {1'b0, count_q} + (half ? 17'd1 : 17'd2);
		new_count = raw_count[16] ? 16'hFFFF : raw_count[15:0];
		new_sat   = sat_q || raw_count[16];
	end

	assign total_push       = accept && last_word;
	assign total_data.sum   = new_sum;
	assign total_data.bytes = new_count;
	assign total_data.sat   = new_sat;

	// hold running state; drop it back to zero at segment end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			sat_q   <= 1'b0;
		end else if (accept) begin
			if (last_word) begin
				sum_q   <= '0;
				count_q <= '0;
				sat_q   <= 1'b0;
			end else begin
				sum_q   <= new_sum;
				count_q <= new_count;
				sat_q   <= new_sat;
			end
		end
	end

endmodule

>>> design/tcpck_back.sv
// Back part: folds the pseudo-header into each segment total and holds the
// finished checksum as the result word. Uses tcpck_pkg.
module tcpck_back import tcpck_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pseudo_cfg_t cfg,
	input  logic        total_valid,
	input  seg_total_t  total_data,
	output logic        total_take,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] checksum_value,
	output logic [15:0] segment_bytes,
	output logic        too_long
);
	logic        valid_s1;
	logic [18:0] raw_s1;
	logic [15:0] bytes_s1;
	logic        sat_s1;

	logic        valid_q;
	logic [15:0] csum_q;
	logic [15:0] bytes_q;
	logic        sat_q;

	logic        out_free;
	logic        load_s1;
	logic [18:0] raw_sum;
	logic [16:0] fold1;
	logic [15:0] fold2;

	assign out_free   = !valid_q || pop;
	assign load_s1    = total_valid && (!valid_s1 || out_free);
	assign total_take = load_s1;

	// plain sum of the segment sum and the pseudo-header words
	assign raw_sum = {3'd0, total_data.sum}
		+ {3'd0, cfg.source_ip[31:16]} + {3'd0, cfg.source_ip[15:0]}
		+ {3'd0, cfg.dest_ip[31:16]} + {3'd0, cfg.dest_ip[15:0]}
		+ {3'd0, cfg.pseudo_reserved, cfg.protocol_number}
		+ {3'd0, total_data.bytes};

	// fold carries back in twice
	assign fold1 = {1'b0, raw_s1[15:0]} + {14'd0, raw_s1[18:16]};
	assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

	// advance sum stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			raw_s1   <= raw_sum;
			bytes_s1 <= total_data.bytes;
			sat_s1   <= total_data.sat;
		end
	end

	// hold the result word until it is popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			csum_q  <= ~fold2;
			bytes_q <= bytes_s1;
			sat_q   <= sat_s1;
		end
	end

	assign empty          = !valid_q;
	assign checksum_value = csum_q;
	assign segment_bytes  = bytes_q;
	assign too_long       = sat_q;

endmodule

>>> design/tcp_checksum_with_pseudo_header_unit.sv
// TCP checksum with pseudo-header: top level, config registers and queue.
// Takes one segment word per cycle while full is low; a result word follows
// the edge that accepts the last word (queue write, then sum and fold stages).
// Throughput is one word per cycle while not full, set by the single end-around adder in front.
// Reset (arst_n low, asynchronous) clears the running sum, count and queues;
// registers return to zero except protocol_number, which returns to 6.
module tcp_checksum_with_pseudo_header_unit import tcpck_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] segment_word,
	input  logic        last_word,
	input  logic        single_byte,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] checksum_value,
	output logic [15:0] segment_bytes,
	output logic        too_long,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	pseudo_cfg_t cfg_q;
	logic        accept;
	logic        total_push;
	seg_total_t  total_in;
	seg_total_t  total_out;
	logic        q_empty;
	logic        total_take;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	// write configuration registers; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_ip       <= '0;
			cfg_q.dest_ip         <= '0;
			cfg_q.pseudo_reserved <= '0;
			cfg_q.protocol_number <= PROTOCOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SOURCE_IP:       cfg_q.source_ip       <= cfg_data;
				REG_DEST_IP:         cfg_q.dest_ip         <= cfg_data;
				REG_PSEUDO_RESERVED: cfg_q.pseudo_reserved <= cfg_data[7:0];
				REG_PROTOCOL_NUMBER: cfg_q.protocol_number <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	tcpck_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.segment_word (segment_word),
		.last_word    (last_word),
		.single_byte  (single_byte),
		.total_push   (total_push),
		.total_data   (total_in)
	);

	tcpck_fifo #(
		.WIDTH ($bits(seg_total_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (total_push),
		.wr_data (total_in),
		.full    (full),
		.rd_en   (total_take),
		.rd_data (total_out),
		.empty   (q_empty)
	);

	tcpck_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.total_valid    (!q_empty),
		.total_data     (total_out),
		.total_take     (total_take),
		.empty          (empty),
		.pop            (pop),
		.checksum_value (checksum_value),
		.segment_bytes  (segment_bytes),
		.too_long       (too_long)
	);

endmodule

>>> test/tcp_checksum_with_pseudo_header_unit_tb.sv
// Self-checking testbench for tcp_checksum_with_pseudo_header_unit.
// Depends on tcpck_pkg (register indexes, reset protocol, checksum field offset)
// and on the unit itself; predicts each segment checksum and compares field by field.
module tcp_checksum_with_pseudo_header_unit_tb;
	import tcpck_pkg::*;

	localparam int SETTLE_CYCLES = 10;

	typedef struct packed {
		logic [15:0] csum;
		logic [15:0] nbytes;
		logic        sat;
	} seg_result_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [15:0] segment_word;
	logic        last_word;
	logic        single_byte;
	logic        empty;
	logic        pop;
	logic [15:0] checksum_value;
	logic [15:0] segment_bytes;
	logic        too_long;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	// pseudo-header registers and running segment totals, as the unit should hold them
	logic [31:0] pseudo_src;
	logic [31:0] pseudo_dst;
	logic [7:0]  pseudo_rsv;
	logic [7:0]  pseudo_proto;
	logic [15:0] seg_sum;
	logic [15:0] seg_count;
	logic        seg_sat;

	seg_result_t expected_checksums[$];
	int          mismatch_count = 0;
	int          send_gap = 0;
	int          pop_stall = 0;

	tcp_checksum_with_pseudo_header_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.segment_word   (segment_word),
		.last_word      (last_word),
		.single_byte    (single_byte),
		.empty          (empty),
		.pop            (pop),
		.checksum_value (checksum_value),
		.segment_bytes  (segment_bytes),
		.too_long       (too_long),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ones-complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	// fold one accepted segment word into the totals; close the segment on last
	task automatic fold_segment_word(input logic [15:0] w, input logic last, input logic sb);
		logic        half;
		logic [15:0] v;
		logic [16:0] cnt;
		logic [15:0] s;
		seg_result_t r;
		half = last && sb;
		v = half ? {w[15:8], 8'h00} : w;
		if (!seg_sat && seg_count == CSUM_FIELD_BYTE)
			v = 16'h0000;
		seg_sum = oc_add(seg_sum, v);
		cnt = {1'b0, seg_count} + (half ? 17'd1 : 17'd2);
		if (cnt > 17'hFFFF) begin
			cnt = 17'hFFFF;
			seg_sat = 1'b1;
		end
		seg_count = cnt[15:0];
		if (last) begin
			s = oc_add(seg_sum, pseudo_src[31:16]);
			s = oc_add(s, pseudo_src[15:0]);
			s = oc_add(s, pseudo_dst[31:16]);
			s = oc_add(s, pseudo_dst[15:0]);
			s = oc_add(s, {pseudo_rsv, pseudo_proto});
			s = oc_add(s, seg_count);
			r.csum = ~s;
			r.nbytes = seg_count;
			r.sat = seg_sat;
			expected_checksums.insert(expected_checksums.size(), r);
			seg_sum = '0;
			seg_count = '0;
			seg_sat = 1'b0;
		end
	endtask

	// offer one word, with random idle cycles ahead of it; hold until accepted
	task automatic send_segment_word(input logic [15:0] w, input logic last, input logic sb);
		while ($urandom_range(99) < send_gap) begin
			push <= 1'b0;
			segment_word <= 16'($urandom);
			last_word <= 1'($urandom);
			single_byte <= 1'($urandom);
			@(posedge clk);
		end
		push <= 1'b1;
		segment_word <= w;
		last_word <= last;
		single_byte <= sb;
		do @(posedge clk); while (full);
		fold_segment_word(w, last, sb);
	endtask

	task automatic stop_pushing();
		push <= 1'b0;
	endtask

	// write one register and mirror it in the predictor
	task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SOURCE_IP:       pseudo_src = data;
			REG_DEST_IP:         pseudo_dst = data;
			REG_PSEUDO_RESERVED: pseudo_rsv = data[7:0];
			REG_PROTOCOL_NUMBER: pseudo_proto = data[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_pseudo_header(input logic [31:0] src, input logic [31:0] dst,
			input logic [7:0] rsv, input logic [7:0] proto);
		write_register(REG_SOURCE_IP, src);
		write_register(REG_DEST_IP, dst);
		write_register(REG_PSEUDO_RESERVED, {24'hA5A5A5, rsv});
		write_register(REG_PROTOCOL_NUMBER, {24'h5A5A5A, proto});
	endtask

	// wait for every expected checksum, then let the pipeline settle
	task automatic wait_checksums_drained();
		while (expected_checksums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		seg_result_t exp_r;
		if (arst_n && pop && !empty) begin
			if (expected_checksums.size() == 0) begin
				$error("unexpected result: checksum_value %h segment_bytes %h too_long %b",
					checksum_value, segment_bytes, too_long);
				mismatch_count++;
			end else begin
				exp_r = expected_checksums.pop_front();
				if (checksum_value !== exp_r.csum) begin
					$error("checksum_value: expected %h, got %h", exp_r.csum, checksum_value);
					mismatch_count++;
				end
				if (segment_bytes !== exp_r.nbytes) begin
					$error("segment_bytes: expected %h, got %h", exp_r.nbytes, segment_bytes);
					mismatch_count++;
				end
				if (too_long !== exp_r.sat) begin
					$error("too_long: expected %b, got %b", exp_r.sat, too_long);
					mismatch_count++;
				end
			end
		end
	end

	// receiver: stall pop at the rate of the current phase
	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			pop <= ($urandom_range(99) >= pop_stall);
		end
	end

	// reset register values, short and padded segments
	task automatic test_reset_values();
		send_segment_word(16'h0000, 1'b1, 1'b0);
		send_segment_word(16'hFFFF, 1'b0, 1'b0);
		send_segment_word(16'hABCD, 1'b1, 1'b1);
		stop_pushing();
		wait_checksums_drained();
	endtask

	// all-ones and all-zero registers, ignored indexes, checksum of zero
	task automatic test_register_extremes();
		write_pseudo_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
		send_segment_word(16'h1234, 1'b0, 1'b0);
		send_segment_word(16'h00FF, 1'b1, 1'b0);
		stop_pushing();
		wait_checksums_drained();
		write_register(3'd4, 32'h0000_0000);
		write_register(3'd5, 32'hFFFF_FFFF);
		write_register(3'd6, 32'h1234_5678);
		write_register(3'd7, 32'hFFFF_FFFF);
		send_segment_word(16'h80FF, 1'b1, 1'b1);
		stop_pushing();
		wait_checksums_drained();
		write_pseudo_header(32'h0, 32'h0, 8'h00, 8'h00);
		// sum lands on all ones, so the checksum is zero
		send_segment_word(16'hFFFD, 1'b1, 1'b0);
		stop_pushing();
		wait_checksums_drained();
	endtask

	// checksum field zeroed, single_byte ignored before last, odd tail padded
	task automatic test_checksum_field_and_padding();
		write_pseudo_header(32'hC0A8_0001, 32'h0A00_0002, 8'h00, PROTOCOL_RESET);
		for (int k = 0; k < 10; k++)
			send_segment_word(16'hFFFF, k == 9, k == 3 || k == 9);
		// checksum field is itself the last, odd word
		for (int k = 0; k < 9; k++)
			send_segment_word(16'(16'h8001 + k), k == 8, k == 8);
		stop_pushing();
		wait_checksums_drained();
	endtask

	// long segments of 64 and 65 words, with odd and even tails
	task automatic test_long_segments();
		write_pseudo_header($urandom, $urandom, 8'($urandom), 8'($urandom));
		for (int k = 0; k < 64; k++)
			send_segment_word(16'($urandom), k == 63, k == 63);
		for (int k = 0; k < 65; k++)
			send_segment_word(16'($urandom), k == 64, 1'b0);
		stop_pushing();
		wait_checksums_drained();
	endtask

	// random segments with random content under one idling mode
	task automatic test_random_traffic(input int gap, input int stall, input int words_budget);
		int          sent;
		int          seg_len;
		int          pick;
		logic [15:0] w;
		logic        last;
		logic        sb;
		send_gap = gap;
		pop_stall = stall;
		sent = 0;
		while (sent < words_budget) begin
			pick = $urandom_range(99);
			if (pick < 10)
				seg_len = 1;
			else if (pick < 75)
				seg_len = $urandom_range(2, 16);
			else if (pick < 95)
				seg_len = $urandom_range(17, 40);
			else
				seg_len = $urandom_range(41, 120);
			for (int k = 0; k < seg_len; k++) begin
				pick = $urandom_range(9);
				w = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
				last = (k == seg_len - 1);
				sb = last ? 1'($urandom_range(1)) : ($urandom_range(9) == 0);
				send_segment_word(w, last, sb);
				sent++;
			end
		end
		stop_pushing();
		wait_checksums_drained();
		send_gap = 0;
		pop_stall = 0;
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		segment_word <= '0;
		last_word <= 1'b0;
		single_byte <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		pseudo_src = '0;
		pseudo_dst = '0;
		pseudo_rsv = '0;
		pseudo_proto = PROTOCOL_RESET;
		seg_sum = '0;
		seg_count = '0;
		seg_sat = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_register_extremes();
		test_checksum_field_and_padding();
		test_long_segments();

		write_pseudo_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
		test_random_traffic(0, 0, 150);
		write_pseudo_header(32'h0, 32'h0, 8'h00, 8'h00);
		test_random_traffic(51, 0, 150);
		write_pseudo_header($urandom, $urandom, 8'($urandom), 8'($urandom));
		test_random_traffic(0, 51, 150);
		write_pseudo_header($urandom, $urandom, 8'($urandom), 8'($urandom));
		test_random_traffic(37, 37, 150);

		wait_checksums_drained();
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// hard stop in case the unit hangs
	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
design/tcpck_pkg.sv
design/tcpck_fifo.sv
design/tcpck_front.sv
design/tcpck_back.sv
design/tcp_checksum_with_pseudo_header_unit.sv
test/tcp_checksum_with_pseudo_header_unit_tb.sv
